>>> rtl/core/acp_pkg.sv
// Shared types and constants for the allpass cascade phaser core.
`timescale 1ns / 1ps

package acp_pkg;

  localparam int MAX_STAGES_DEF  = 10;
  localparam int SAMPLE_BITS_DEF = 24;

  localparam int COEF_W     = 16;
  localparam int AMT_W      = 15;
  localparam int CNT_W      = 4;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int FRAC_BITS  = 15;
  localparam int HALF_Q15   = 16384;
  localparam int COEF_LIMIT = 32440;
  localparam int STAGE_CNT_RESET = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEFFICIENT     = 3'd0,
    REG_FEEDBACK_AMOUNT = 3'd1,
    REG_FEEDBACK_INVERT = 3'd2,
    REG_NUM_STAGES      = 3'd3,
    REG_MIX_INVERT      = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FB_MUL,
    ST_FB_ADD,
    ST_MUL,
    ST_FIN,
    ST_MIX
  } st_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef;
    logic signed [COEF_W-1:0] gain;
    logic                     fb_on;
    logic                     mix_inv;
    logic [CNT_W-1:0]         last_stage;
  } cfg_t;

endpackage

>>> rtl/core/acp_cfg.sv
// Configuration registers and derived operating settings.
`timescale 1ns / 1ps

module acp_cfg #(
  parameter int MAX_STAGES = acp_pkg::MAX_STAGES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [acp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [acp_pkg::CFG_DATA_W-1:0]   cfg_data,
  output acp_pkg::cfg_t                    cfg
);

  localparam logic [5:0] MAX_N = 6'(MAX_STAGES);
  localparam logic signed [acp_pkg::COEF_W-1:0] C_HI = acp_pkg::COEF_W'(acp_pkg::COEF_LIMIT);
  localparam logic signed [acp_pkg::COEF_W-1:0] C_LO = -C_HI;

  logic signed [acp_pkg::COEF_W-1:0] coefficient;
  logic [acp_pkg::AMT_W-1:0]         feedback_amount;
  logic                              feedback_invert;
  logic [acp_pkg::CNT_W-1:0]         stage_req;
  logic                              mix_invert;

  logic [5:0] n_clamp;
  logic [5:0] n_eff;
  logic signed [acp_pkg::COEF_W-1:0] amt_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      coefficient     <= '0;
      feedback_amount <= '0;
      feedback_invert <= 1'b0;
      stage_req       <= acp_pkg::CNT_W'(acp_pkg::STAGE_CNT_RESET);
      mix_invert      <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        acp_pkg::REG_COEFFICIENT:     coefficient     <= cfg_data;
        acp_pkg::REG_FEEDBACK_AMOUNT: feedback_amount <= cfg_data[acp_pkg::AMT_W-1:0];
        acp_pkg::REG_FEEDBACK_INVERT: feedback_invert <= cfg_data[0];
        acp_pkg::REG_NUM_STAGES:      stage_req       <= cfg_data[acp_pkg::CNT_W-1:0];
        acp_pkg::REG_MIX_INVERT:      mix_invert      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    n_clamp = {2'b00, stage_req};
    if (n_clamp < 6'd2) n_clamp = 6'd2;
    if (n_clamp > MAX_N) n_clamp = MAX_N;
    n_eff = n_clamp;
    if (n_clamp[0]) begin
      n_eff = n_clamp + 6'd1;
      if (n_eff > MAX_N) n_eff = n_clamp - 6'd1;
    end
  end

  assign amt_s = {1'b0, feedback_amount};

  always_comb begin
    if (coefficient > C_HI) cfg.coef = C_HI;
    else if (coefficient < C_LO) cfg.coef = C_LO;
    else cfg.coef = coefficient;
    cfg.gain       = feedback_invert ? -amt_s : amt_s;
    cfg.fb_on      = (feedback_amount != '0);
    cfg.mix_inv    = mix_invert;
    cfg.last_stage = acp_pkg::CNT_W'(n_eff - 6'd1);
  end

endmodule

>>> rtl/core/acp_mem.sv
// Stage state memory: previous input and output of each allpass stage.
`timescale 1ns / 1ps

module acp_mem #(
  parameter int DEPTH = acp_pkg::MAX_STAGES_DEF,
  parameter int DW    = 2 * acp_pkg::SAMPLE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DW-1:0]            rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DW-1:0]            wr_data
);

  logic [DW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [DW-1:0]    rd_q;
  logic             rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) vld[wr_addr] <= 1'b1;
      if (rd_en) rd_vld <= vld[rd_addr];
    end
  end

  assign rd_data = rd_vld ? rd_q : '0;

endmodule

>>> rtl/core/acp_engine.sv
// Sequencer and arithmetic: feedback, stage recursion, dry/wet mix, output register.
`timescale 1ns / 1ps

module acp_engine #(
  parameter int MAX_STAGES  = acp_pkg::MAX_STAGES_DEF,
  parameter int SAMPLE_BITS = acp_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  acp_pkg::cfg_t                   cfg,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [SAMPLE_BITS-1:0]   sample_in,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [SAMPLE_BITS-1:0]   sample_out,
  output logic                            clipped,
  output logic                            rd_en,
  output logic [$clog2(MAX_STAGES)-1:0]   rd_addr,
  input  logic [2*SAMPLE_BITS-1:0]        rd_data,
  output logic                            wr_en,
  output logic [$clog2(MAX_STAGES)-1:0]   wr_addr,
  output logic [2*SAMPLE_BITS-1:0]        wr_data
);

  localparam int SW    = SAMPLE_BITS;
  localparam int IDX_W = $clog2(MAX_STAGES);
  localparam int AW    = SW + 1;
  localparam int PW    = SW + acp_pkg::COEF_W + 1;
  localparam int WW    = SW + acp_pkg::COEF_W + 2;
  localparam logic signed [WW-1:0] HALF   = WW'(acp_pkg::HALF_Q15);
  localparam logic signed [WW-1:0] SAT_HI = {{(WW-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [WW-1:0] SAT_LO = ~SAT_HI;
  localparam logic signed [SW-1:0] OUT_HI = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] OUT_LO = {1'b1, {(SW-1){1'b0}}};

  acp_pkg::st_t state, state_next;

  logic signed [SW-1:0]  dry;
  logic signed [SW-1:0]  v;
  logic [IDX_W-1:0]      idx;
  logic                  clip;
  logic signed [PW-1:0]  prod;

  logic                  acc;
  logic                  out_free;
  logic                  last_hit;
  logic [IDX_W-1:0]      last_idx;
  logic signed [SW-1:0]  rd_in;
  logic signed [SW-1:0]  rd_out;
  logic signed [AW-1:0]  mul_a;
  logic signed [acp_pkg::COEF_W-1:0] mul_b;
  logic signed [PW-1:0]  mul_p;
  logic signed [WW-1:0]  rnd;
  logic signed [WW-1:0]  pre;
  logic signed [SW-1:0]  satv;
  logic                  sat_flag;

  assign last_idx = IDX_W'(cfg.last_stage);
  assign last_hit = (idx == last_idx);
  assign out_free = !(out_valid && out_stall);
  assign acc      = in_valid && !in_stall;
  assign rd_in    = $signed(rd_data[2*SW-1:SW]);
  assign rd_out   = $signed(rd_data[SW-1:0]);

  always_ff @(posedge clk) begin
    if (rst) state <= acp_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    rd_en      = 1'b0;
    rd_addr    = IDX_W'(1);
    wr_en      = 1'b0;
    unique case (state)
      acp_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          rd_en      = 1'b1;
          rd_addr    = cfg.fb_on ? last_idx : IDX_W'(1);
          state_next = cfg.fb_on ? acp_pkg::ST_FB_MUL : acp_pkg::ST_MUL;
        end
      end
      acp_pkg::ST_FB_MUL: begin
        rd_en      = 1'b1;
        state_next = acp_pkg::ST_FB_ADD;
      end
      acp_pkg::ST_FB_ADD: state_next = acp_pkg::ST_MUL;
      acp_pkg::ST_MUL:    state_next = acp_pkg::ST_FIN;
      acp_pkg::ST_FIN: begin
        wr_en = 1'b1;
        if (last_hit) begin
          state_next = acp_pkg::ST_MIX;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = IDX_W'(idx + 1'b1);
          state_next = acp_pkg::ST_MUL;
        end
      end
      acp_pkg::ST_MIX: if (out_free) state_next = acp_pkg::ST_IDLE;
      default: state_next = acp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    if (state == acp_pkg::ST_FB_MUL) begin
      mul_a = AW'(rd_out);
      mul_b = cfg.gain;
    end else begin
      mul_a = AW'(rd_out) + AW'(v);
      mul_b = cfg.coef;
    end
  end

  assign mul_p = mul_a * mul_b;
  assign rnd   = (WW'(prod) + HALF) >>> acp_pkg::FRAC_BITS;

  always_comb begin
    priority case (state)
      acp_pkg::ST_FB_ADD: pre = WW'(dry) + rnd;
      acp_pkg::ST_FIN:    pre = rnd - WW'(rd_in);
      default:            pre = cfg.mix_inv ? WW'(dry) - WW'(v) : WW'(dry) + WW'(v);
    endcase
    sat_flag = 1'b1;
    if (pre > SAT_HI) satv = OUT_HI;
    else if (pre < SAT_LO) satv = OUT_LO;
    else begin
      satv     = pre[SW-1:0];
      sat_flag = 1'b0;
    end
  end

  assign wr_addr = idx;
  assign wr_data = {v, satv};

  always_ff @(posedge clk) begin
    if (acc) begin
      dry  <= sample_in;
      v    <= sample_in;
      idx  <= IDX_W'(1);
      clip <= 1'b0;
    end
    if (state == acp_pkg::ST_FB_MUL || state == acp_pkg::ST_MUL) prod <= mul_p;
    if (state == acp_pkg::ST_FB_ADD || state == acp_pkg::ST_FIN) begin
      v    <= satv;
      clip <= clip | sat_flag;
    end
    if (state == acp_pkg::ST_FIN) idx <= IDX_W'(idx + 1'b1);
    if (state == acp_pkg::ST_MIX && out_free) begin
      sample_out <= satv;
      clipped    <= clip | sat_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (state == acp_pkg::ST_MIX && out_free) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

`ifndef SYNTHESIS
  a_wr_range: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (wr_addr != '0 && wr_addr <= last_idx))
    else $error("stage write outside active range");

  a_mix_load: assert property (@(posedge clk) disable iff (rst)
    (state == acp_pkg::ST_MIX && out_free) |=> (out_valid && state == acp_pkg::ST_IDLE))
    else $error("mixed result not presented");

  a_start: assert property (@(posedge clk) disable iff (rst)
    acc |=> (v == $past(sample_in) && !clip && idx == IDX_W'(1)))
    else $error("request not captured cleanly");
`endif

endmodule

>>> rtl/core/allpass_cascade_phaser_core.sv
// Top level of the allpass cascade phaser core.
// Usage:
//  Input channel: sample_in with in_valid / in_stall; a request is taken at a
//  rising edge with in_valid high and in_stall low.
//  Output channel: sample_out and clipped with out_valid / out_stall, held
//  in an output register until taken.
//  Configuration: cfg_write, cfg_index, cfg_data; write only while idle.
//  Timing: a request occupies the engine from the idle state through the
//  feedback states when feedback is on, the stage loop and the mix state,
//  which loads the result into the output register; out_valid rises in the
//  next cycle. The engine takes no new request until it is done with the
//  current one. The stage loop dominates: each stage takes a multiply state
//  and a round/saturate/write-back state, with one shared multiplier.
//  A new request is taken while the previous result waits in the output
//  register; if the receiver stalls, the next result holds in the engine
//  and in_stall stays high until the register frees.
//  Reset: configuration registers, sequencer state and out_valid return to
//  their defaults and all stage state reads as zero at once; no clearing pass.
`timescale 1ns / 1ps

module allpass_cascade_phaser_core #(
  parameter int MAX_STAGES  = acp_pkg::MAX_STAGES_DEF,
  parameter int SAMPLE_BITS = acp_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [acp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [acp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [SAMPLE_BITS-1:0]   sample_in,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [SAMPLE_BITS-1:0]   sample_out,
  output logic                            clipped
);

  localparam int IDX_W = $clog2(MAX_STAGES);
  localparam int DW    = 2 * SAMPLE_BITS;

  acp_pkg::cfg_t    cfg;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [DW-1:0]    rd_data;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [DW-1:0]    wr_data;

  acp_cfg #(
    .MAX_STAGES(MAX_STAGES)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  acp_mem #(
    .DEPTH(MAX_STAGES),
    .DW   (DW)
  ) u_mem (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

  acp_engine #(
    .MAX_STAGES (MAX_STAGES),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample_in (sample_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sample_out(sample_out),
    .clipped   (clipped),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

endmodule
